### rtl/core/bdf_pkg.sv
package bdf_pkg;

    typedef enum logic [6:0] {
        ST_LOAD   = 7'b0000001,
        ST_PUSH   = 7'b0000010,
        ST_NBR    = 7'b0000100,
        ST_UPD    = 7'b0001000,
        ST_DIV    = 7'b0010000,
        ST_EMIT   = 7'b0100000,
        ST_OUTW   = 7'b1000000
    } state_t;

    // Neighbor order: left, up, right, down.
    localparam int unsigned NB_COUNT = 4;
    localparam int unsigned SUM_W    = 10;
    localparam int unsigned CNT_W    = 3;
    localparam int unsigned COLOR_W  = 8;

endpackage

### rtl/core/block_dilation_fill_top.sv
// Block dilation fill. The block takes BLOCK_SIZE*BLOCK_SIZE pixel items in
// raster order, one a cycle while loading, then decides per block: when no
// coarse bit was set or every pixel is occupied, the pixels come back out
// unchanged. Otherwise a dilation runs in rounds. Each round scans every
// pixel, and a pixel labelled with the round pushes its color into the free
// 4-neighbors (through the shared accumulator port of the sum memory). After
// the push scan every reached pixel is averaged per channel by one shared
// serial divider. The rounds stop when no empty pixel remains or after round
// N-1. The block is not ready for input from the last pixel of a block until
// its last result item has been taken; results come out from a registered
// output, block_last marking the final pixel. A full block costs N loads, N
// result items, and per round a push scan and an update scan with their
// push and divide work. Stores need no clearing pass: sums and counts are
// cleared as they are consumed.
module block_dilation_fill_top
    import bdf_pkg::*;
#(
    parameter int BLOCK_SIZE = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [7:0]   red_in,
    input  logic [7:0]   green_in,
    input  logic [7:0]   blue_in,
    input  logic         pixel_occupied,
    input  logic         coarse_occupied,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [7:0]   red_out,
    output logic [7:0]   green_out,
    output logic [7:0]   blue_out,
    output logic         block_last
);

    localparam int N  = BLOCK_SIZE * BLOCK_SIZE;
    localparam int AW = (N > 1) ? $clog2(N) : 1;
    localparam int BW = $clog2(BLOCK_SIZE);
    localparam int LW = $clog2(N + 1);
    localparam int PW = 3 * COLOR_W;
    localparam int SW = 3 * SUM_W + CNT_W;

    state_t state_reg, state_next;

    logic [AW-1:0] idx_reg, idx_next;
    logic [BW-1:0] col_reg, col_next;
    logic [BW-1:0] row_reg, row_next;
    logic [1:0]    ph_reg, ph_next;
    logic [1:0]    k_reg, k_next;
    logic [LW-1:0] round_reg, round_next;
    logic [LW-1:0] empty_reg, empty_next;
    logic          coarse_reg, coarse_next;
    logic [1:0]    ch_reg, ch_next;
    logic [PW-1:0] res_reg, res_next;

    // Memories: pixel colors, labels, and sums with counts.
    logic          p_we, l_we, s_we;
    logic [AW-1:0] p_wa, l_wa, s_wa, p_ra, l_ra, s_ra;
    logic [PW-1:0] p_wd, p_rd;
    logic [LW-1:0] l_wd, l_rd;
    logic [SW-1:0] s_wd, s_rd;

    // Label memory, a second copy so push can check the neighbor label.
    logic [LW-1:0] l2_rd;
    logic [AW-1:0] l2_ra;

    bdf_ram #(.WIDTH(PW), .DEPTH(N)) u_pix (.clk(clk), .we(p_we), .waddr(p_wa),
        .wdata(p_wd), .raddr(p_ra), .rdata(p_rd));
    bdf_ram #(.WIDTH(LW), .DEPTH(N)) u_lab (.clk(clk), .we(l_we), .waddr(l_wa),
        .wdata(l_wd), .raddr(l_ra), .rdata(l_rd));
    bdf_ram #(.WIDTH(LW), .DEPTH(N)) u_lab2 (.clk(clk), .we(l_we), .waddr(l_wa),
        .wdata(l_wd), .raddr(l2_ra), .rdata(l2_rd));
    bdf_ram #(.WIDTH(SW), .DEPTH(N)) u_sum (.clk(clk), .we(s_we), .waddr(s_wa),
        .wdata(s_wd), .raddr(s_ra), .rdata(s_rd));

    // Divider.
    logic             dv_start, dv_done;
    logic [SUM_W-1:0] dv_a, dv_q;
    logic [CNT_W-1:0] dv_b;

    bdf_div u_div (.clk(clk), .rst_n(rst_n), .start(dv_start), .dividend(dv_a),
        .divisor(dv_b), .done(dv_done), .quotient(dv_q));

    // Output register.
    logic          ov_reg, ov_next;
    logic [PW-1:0] od_reg, od_next;
    logic          ol_reg, ol_next;

    assign out_valid  = ov_reg;
    assign red_out    = od_reg[23:16];
    assign green_out  = od_reg[15:8];
    assign blue_out   = od_reg[7:0];
    assign block_last = ol_reg;
    assign in_ready   = (state_reg == ST_LOAD) && !ov_reg;

    // Neighbor address of idx_reg in direction k_reg. The column and row of
    // idx_reg are tracked in counters that step along with it.
    logic [BW-1:0] u_c, v_c;
    logic          nb_ok;
    logic [AW-1:0] nb_addr;

    always_comb
    begin
        u_c     = col_reg;
        v_c     = row_reg;
        nb_ok   = 1'b0;
        nb_addr = idx_reg;
        unique case (k_reg)
            2'd0:
            begin
                nb_ok   = (u_c != '0);
                nb_addr = AW'(idx_reg - AW'(1));
            end
            2'd1:
            begin
                nb_ok   = (v_c != '0);
                nb_addr = AW'(idx_reg - AW'(BLOCK_SIZE));
            end
            2'd2:
            begin
                nb_ok   = (u_c != BW'(BLOCK_SIZE - 1));
                nb_addr = AW'(idx_reg + AW'(1));
            end
            default:
            begin
                nb_ok   = (v_c != BW'(BLOCK_SIZE - 1));
                nb_addr = AW'(idx_reg + AW'(BLOCK_SIZE));
            end
        endcase
    end

    logic [CNT_W-1:0] cnt;
    logic [SUM_W-1:0] sel_sum;
    logic             last_idx;

    assign cnt      = s_rd[CNT_W-1:0];
    assign last_idx = (idx_reg == AW'(N - 1));

    // The dividend follows the channel that the divider starts on.
    always_comb
    begin
        unique case (ch_next)
            2'd0:    sel_sum = s_rd[SW-1 -: SUM_W];
            2'd1:    sel_sum = s_rd[SW-1-SUM_W -: SUM_W];
            default: sel_sum = s_rd[CNT_W +: SUM_W];
        endcase
    end

    assign dv_a = SUM_W'(sel_sum + SUM_W'(cnt >> 1));
    assign dv_b = cnt;

    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        ph_next     = ph_reg;
        k_next      = k_reg;
        round_next  = round_reg;
        empty_next  = empty_reg;
        coarse_next = coarse_reg;
        ch_next     = ch_reg;
        res_next    = res_reg;
        ov_next     = ov_reg;
        od_next     = od_reg;
        ol_next     = ol_reg;
        p_we = 1'b0; p_wa = idx_reg; p_wd = {red_in, green_in, blue_in};
        l_we = 1'b0; l_wa = idx_reg; l_wd = LW'(pixel_occupied);
        s_we = 1'b0; s_wa = idx_reg; s_wd = '0;
        p_ra = idx_reg; l_ra = idx_reg; l2_ra = nb_addr; s_ra = idx_reg;
        dv_start = 1'b0;

        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end

        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_valid && in_ready)
                begin
                    p_we = 1'b1;
                    l_we = 1'b1;
                    // Sums start clean for this pixel.
                    s_we = 1'b1;
                    coarse_next = coarse_reg | coarse_occupied;
                    if (!pixel_occupied)
                    begin
                        empty_next = LW'(empty_reg + LW'(1));
                    end
                    if (last_idx)
                    begin
                        idx_next   = '0;
                        ph_next    = '0;
                        k_next     = '0;
                        round_next = LW'(1);
                        if ((coarse_reg | coarse_occupied) &&
                            (empty_reg != '0 || !pixel_occupied))
                        begin
                            state_next = ST_PUSH;
                        end
                        else
                        begin
                            state_next = ST_EMIT;
                        end
                    end
                    else
                    begin
                        idx_next = AW'(idx_reg + AW'(1));
                    end
                end
            end
            ST_PUSH:
            begin
                // Phase 0 reads label and pixel; phase 1 decides.
                if (ph_reg == 2'd0)
                begin
                    ph_next = 2'd1;
                end
                else
                begin
                    ph_next = 2'd0;
                    if (l_rd == round_reg)
                    begin
                        k_next     = '0;
                        state_next = ST_NBR;
                    end
                    else if (last_idx)
                    begin
                        idx_next   = '0;
                        state_next = ST_UPD;
                    end
                    else
                    begin
                        idx_next = AW'(idx_reg + AW'(1));
                    end
                end
            end
            ST_NBR:
            begin
                // Phase 0: read neighbor label and sum. Phase 1: accumulate.
                s_ra = nb_addr;
                if (ph_reg == 2'd0)
                begin
                    ph_next = 2'd1;
                end
                else
                begin
                    ph_next = 2'd0;
                    if (nb_ok && l2_rd == '0)
                    begin
                        s_we = 1'b1;
                        s_wa = nb_addr;
                        s_wd = {SUM_W'(s_rd[SW-1 -: SUM_W] + SUM_W'(p_rd[23:16])),
                                SUM_W'(s_rd[SW-1-SUM_W -: SUM_W] + SUM_W'(p_rd[15:8])),
                                SUM_W'(s_rd[CNT_W +: SUM_W] + SUM_W'(p_rd[7:0])),
                                CNT_W'(cnt + CNT_W'(1))};
                    end
                    k_next = k_reg + 2'd1;
                    if (k_reg == 2'd3)
                    begin
                        if (last_idx)
                        begin
                            idx_next   = '0;
                            state_next = ST_UPD;
                        end
                        else
                        begin
                            idx_next   = AW'(idx_reg + AW'(1));
                            state_next = ST_PUSH;
                        end
                    end
                end
            end
            ST_UPD:
            begin
                if (ph_reg == 2'd0)
                begin
                    ph_next = 2'd1;
                end
                else if (cnt != '0)
                begin
                    ph_next    = 2'd0;
                    ch_next    = 2'd0;
                    dv_start   = 1'b1;
                    state_next = ST_DIV;
                end
                else
                begin
                    ph_next = 2'd0;
                    if (last_idx)
                    begin
                        idx_next = '0;
                        if (empty_reg == '0 || round_reg == LW'(N - 1))
                        begin
                            state_next = ST_EMIT;
                        end
                        else
                        begin
                            round_next = LW'(round_reg + LW'(1));
                            state_next = ST_PUSH;
                        end
                    end
                    else
                    begin
                        idx_next = AW'(idx_reg + AW'(1));
                    end
                end
            end
            ST_DIV:
            begin
                if (dv_done)
                begin
                    res_next = {res_reg[15:0], dv_q[7:0]};
                    if (ch_reg == 2'd2)
                    begin
                        p_we = 1'b1;
                        p_wd = {res_reg[15:0], dv_q[7:0]};
                        l_we = 1'b1;
                        l_wd = LW'(round_reg + LW'(1));
                        s_we = 1'b1;
                        empty_next = LW'(empty_reg - LW'(1));
                        state_next = ST_UPD;
                        ph_next    = 2'd1;
                    end
                    else
                    begin
                        ch_next  = ch_reg + 2'd1;
                        dv_start = 1'b1;
                    end
                end
            end
            ST_EMIT:
            begin
                // Issue read of the pixel at idx_reg.
                if (!ov_reg || out_ready)
                begin
                    state_next = ST_OUTW;
                end
            end
            default:
            begin
                ov_next = 1'b1;
                od_next = p_rd;
                ol_next = last_idx;
                if (last_idx)
                begin
                    idx_next    = '0;
                    empty_next  = '0;
                    coarse_next = 1'b0;
                    state_next  = ST_LOAD;
                end
                else
                begin
                    idx_next   = AW'(idx_reg + AW'(1));
                    state_next = ST_EMIT;
                end
            end
        endcase
        // On the update revisit after a division, the sum entry was cleared,
        // so the last pixel is read again before the scan ends.
        if (state_reg == ST_DIV && dv_done && ch_reg == 2'd2 && !last_idx)
        begin
            idx_next = AW'(idx_reg + AW'(1));
            ph_next  = 2'd0;
        end
        else if (state_reg == ST_DIV && dv_done && ch_reg == 2'd2)
        begin
            ph_next = 2'd0;
        end

        // The pixel index only returns to zero or steps by one.
        if (idx_next == '0)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (idx_next != idx_reg)
        begin
            if (col_reg == BW'(BLOCK_SIZE - 1))
            begin
                col_next = '0;
                row_next = BW'(row_reg + BW'(1));
            end
            else
            begin
                col_next = BW'(col_reg + BW'(1));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_LOAD;
            idx_reg    <= '0;
            col_reg    <= '0;
            row_reg    <= '0;
            ph_reg     <= '0;
            k_reg      <= '0;
            round_reg  <= '0;
            empty_reg  <= '0;
            coarse_reg <= 1'b0;
            ch_reg     <= '0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            ph_reg     <= ph_next;
            k_reg      <= k_next;
            round_reg  <= round_next;
            empty_reg  <= empty_next;
            coarse_reg <= coarse_next;
            ch_reg     <= ch_next;
            ov_reg     <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        od_reg  <= od_next;
        ol_reg  <= ol_next;
    end

endmodule

### rtl/core/bdf_ram.sv
module bdf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/core/bdf_div.sv
// Restoring divider: 10-bit dividend by 3-bit divisor, one quotient bit a cycle.
module bdf_div
    import bdf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [SUM_W-1:0] dividend,
    input  logic [CNT_W-1:0] divisor,
    output logic             done,
    output logic [SUM_W-1:0] quotient
);

    logic [SUM_W-1:0] q_reg, q_next;
    logic [CNT_W:0]   r_reg, r_next;
    logic [3:0]       n_reg, n_next;
    logic             busy_reg, busy_next;
    logic [CNT_W+1:0] trial;

    assign quotient = q_reg;
    assign done     = busy_reg && (n_reg == 4'd0);

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        n_next    = n_reg;
        busy_next = busy_reg;
        trial     = '0;
        if (start)
        begin
            q_next    = dividend;
            r_next    = '0;
            n_next    = 4'(SUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (n_reg == 4'd0)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                trial = {r_reg, q_reg[SUM_W-1]};
                if (trial >= {2'b00, divisor})
                begin
                    r_next = (CNT_W+1)'(trial - {2'b00, divisor});
                    q_next = {q_reg[SUM_W-2:0], 1'b1};
                end
                else
                begin
                    r_next = trial[CNT_W:0];
                    q_next = {q_reg[SUM_W-2:0], 1'b0};
                end
                n_next = n_reg - 4'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            n_reg    <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            n_reg    <= n_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
    end

endmodule

### rtl/core/bdf_checker.sv
module bdf_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] red_out,
    input logic       block_last
);

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid)
        else $error("input item withdrawn before it was taken");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(red_out))
        else $error("result item dropped or changed while stalled");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input accepted while results pending");

    a_last_then_ready: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && block_last |=> in_ready)
        else $error("not ready after the final result item");

endmodule

bind block_dilation_fill_top bdf_checker u_bdf_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .red_out(red_out),
    .block_last(block_last)
);
